// File: sv/status_led_button_sequencer_top_defines.svh
// assertion macros for the status led sequencer
`ifndef STATUS_LED_BUTTON_SEQUENCER_TOP_DEFINES_SVH
`define STATUS_LED_BUTTON_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SLBS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slbs assertion failed");
// next-cycle implication
`define SLBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slbs assertion failed");
`else
`define SLBS_ASSERT_NOW(label, clk, rst, ante, cons)
`define SLBS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: sv/slbs_pkg.sv
package slbs_pkg;

   typedef enum logic [3:0] {
      MODE_IDLE     = 4'd0,
      MODE_READY    = 4'd1,
      MODE_PROC     = 4'd2,
      MODE_FLASH    = 4'd3,
      MODE_DONE_ON  = 4'd4,
      MODE_DONE_OFF = 4'd5,
      MODE_ERROR    = 4'd6,
      MODE_ANIM_OFF = 4'd10,
      MODE_ANIM_ON  = 4'd11,
      MODE_REBOOT   = 4'd12
   } mode_type;

   // modes at or above this code take a fresh press as a reboot request
   localparam logic [3:0] FINAL_MODE_MIN = 4'd4;

   localparam logic [7:0] CMD_CLEAR    = 8'h7a; // z
   localparam logic [7:0] CMD_READY    = 8'h72; // r
   localparam logic [7:0] CMD_PROC     = 8'h70; // p
   localparam logic [7:0] CMD_ERROR    = 8'h65; // e
   localparam logic [7:0] CMD_COMPLETE = 8'h63; // c
   localparam logic [7:0] CMD_FILEDONE = 8'h66; // f

   localparam logic [2:0] LED_G    = 3'b001;
   localparam logic [2:0] LED_Y    = 3'b010;
   localparam logic [2:0] LED_R    = 3'b100;
   localparam logic [2:0] LED_OFF  = 3'b000;
   localparam logic [2:0] LED_ALL  = 3'b111;

   localparam logic [12:0] PRESS_MAX = 13'h1fff;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_LONG_PRESS = 2'd0;
   localparam logic [1:0] REG_BLINK      = 2'd1;
   localparam logic [1:0] REG_REPEATS    = 2'd2;

   localparam logic [11:0] LONG_PRESS_RST = 12'd300;
   localparam logic [7:0]  BLINK_RST      = 8'd30;
   localparam logic [3:0]  REPEATS_RST    = 4'd5;

   typedef struct packed {
      logic [11:0] long_press_ticks;
      logic [7:0]  blink_ticks;
      logic [3:0]  animation_repeats;
   } cfg_type;

   typedef struct packed {
      logic       button_pressed;
      logic       command_valid;
      logic [7:0] command;
   } req_item_type;

   typedef struct packed {
      logic grn_led;
      logic ylw_led;
      logic red_led;
      logic reboot_request;
   } rsp_item_type;

endpackage

// File: sv/slbs_req_if.sv
interface slbs_req_if;
   logic       valid;
   logic       ready;
   logic       button_pressed;
   logic       command_valid;
   logic [7:0] command;

   modport source (output valid, output button_pressed, output command_valid,
                   output command, input ready);
   modport sink (input valid, input button_pressed, input command_valid,
                 input command, output ready);
endinterface

// File: sv/slbs_rsp_if.sv
interface slbs_rsp_if;
   logic valid;
   logic ready;
   logic grn_led;
   logic ylw_led;
   logic red_led;
   logic reboot_request;

   modport source (output valid, output grn_led, output ylw_led,
                   output red_led, output reboot_request, input ready);
   modport sink (input valid, input grn_led, input ylw_led,
                 input red_led, input reboot_request, output ready);
endinterface

// File: sv/slbs_csr.sv
module slbs_csr import slbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [11:0] long_press_ff;
   logic [7:0]  blink_ff;
   logic [3:0]  repeats_ff;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff <= LONG_PRESS_RST;
         blink_ff      <= BLINK_RST;
         repeats_ff    <= REPEATS_RST;
      end else if (wr_en) begin
         case (reg_idx)
            REG_LONG_PRESS: long_press_ff <= pwdata[11:0];
            REG_BLINK:      blink_ff      <= pwdata[7:0];
            REG_REPEATS:    repeats_ff    <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_LONG_PRESS: prdata = {20'd0, long_press_ff};
         REG_BLINK:      prdata = {24'd0, blink_ff};
         REG_REPEATS:    prdata = {28'd0, repeats_ff};
         default:        prdata = '0;
      endcase
   end

   assign cfg.long_press_ticks  = long_press_ff;
   assign cfg.blink_ticks       = blink_ff;
   assign cfg.animation_repeats = repeats_ff;

endmodule

// File: sv/slbs_core.sv
module slbs_core import slbs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   mode_type    mode_ff, mode_in;
   logic [7:0]  tick_ff, tick_in;
   logic [12:0] press_ff, press_in;
   logic        was_pressed_ff, was_pressed_in;
   logic [4:0]  flash_ff, flash_in;
   logic [2:0]  led_ff, led_in;
   logic        halted_ff, halted_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         tick_ff        <= '0;
         press_ff       <= '0;
         was_pressed_ff <= 1'b0;
         flash_ff       <= '0;
         led_ff         <= LED_OFF;
         halted_ff      <= 1'b0;
      end else if (fire) begin
         mode_ff        <= mode_in;
         tick_ff        <= tick_in;
         press_ff       <= press_in;
         was_pressed_ff <= was_pressed_in;
         flash_ff       <= flash_in;
         led_ff         <= led_in;
         halted_ff      <= halted_in;
      end
   end

   // next state for one tick
   always_comb begin
      logic stop;
      stop           = 1'b0;
      mode_in        = mode_ff;
      tick_in        = tick_ff;
      press_in       = press_ff;
      was_pressed_in = was_pressed_ff;
      flash_in       = flash_ff;
      led_in         = led_ff;
      halted_in      = halted_ff;

      if (!halted_ff) begin
         // button
         if (item.button_pressed) begin
            if (press_ff != PRESS_MAX) begin
               press_in = press_ff + 13'd1;
            end
            if (!was_pressed_ff && (4'(mode_ff) >= FINAL_MODE_MIN)) begin
               halted_in      = 1'b1;
               was_pressed_in = 1'b1;
               stop           = 1'b1;
            end else if (press_in == {1'b0, cfg.long_press_ticks}) begin
               mode_in  = MODE_ANIM_OFF;
               flash_in = '0;
            end
         end else begin
            press_in = '0;
         end

         if (!stop) begin
            was_pressed_in = item.button_pressed;

            // command byte
            if (item.command_valid) begin
               case (item.command)
                  CMD_CLEAR: begin
                     led_in  = LED_OFF;
                     mode_in = MODE_IDLE;
                  end
                  CMD_READY: begin
                     led_in  = led_in | LED_G;
                     mode_in = MODE_READY;
                  end
                  CMD_PROC: begin
                     led_in  = (led_in & ~LED_G) | LED_Y;
                     mode_in = MODE_PROC;
                  end
                  CMD_ERROR: begin
                     led_in  = LED_R;
                     mode_in = MODE_ERROR;
                  end
                  CMD_COMPLETE: begin
                     led_in  = (led_in & ~LED_Y) | LED_G;
                     mode_in = MODE_DONE_ON;
                     tick_in = '0;
                  end
                  CMD_FILEDONE: begin
                     led_in  = led_in | LED_G;
                     mode_in = MODE_FLASH;
                     tick_in = '0;
                  end
                  default: ;
               endcase
            end

            // timed advance
            tick_in = tick_in + 8'd1;
            if (tick_in >= cfg.blink_ticks) begin
               tick_in = '0;
               case (mode_in)
                  MODE_FLASH: begin
                     led_in  = led_in & ~LED_G;
                     mode_in = MODE_PROC;
                  end
                  MODE_DONE_ON: begin
                     led_in  = led_in & ~LED_G;
                     mode_in = MODE_DONE_OFF;
                  end
                  MODE_DONE_OFF: begin
                     led_in  = led_in | LED_G;
                     mode_in = MODE_DONE_ON;
                  end
                  MODE_ANIM_OFF: begin
                     led_in  = LED_ALL;
                     mode_in = MODE_ANIM_ON;
                  end
                  MODE_ANIM_ON: begin
                     led_in   = LED_OFF;
                     flash_in = flash_in + 5'd1;
                     mode_in  = (flash_in > {1'b0, cfg.animation_repeats}) ?
                                MODE_REBOOT : MODE_ANIM_OFF;
                  end
                  MODE_REBOOT: halted_in = 1'b1;
                  default: ;
               endcase
            end
         end
      end
   end

   // result of the tick
   always_comb begin
      result.grn_led        = led_in[0];
      result.ylw_led        = led_in[1];
      result.red_led        = led_in[2];
      result.reboot_request = halted_in;
   end

endmodule

// File: sv/status_led_button_sequencer_top.sv
// Status LED and push-button sequencer. Each transfer on the request channel is one timer
// tick carrying the button level and an optional command byte (z, r, p, e, c, f); each tick
// yields exactly one response transfer with the three LED drives and the sticky reboot
// request. A fresh press in a completed, error or animation mode, or the end of the flash
// animation started by a long press, raises reboot_request and freezes the block until
// reset. One tick is taken every clock cycle while responses are taken; a tick is held in
// the input register and the state update is folded into the load of the response
// register, which offers the response until it is taken. Registers sit on the APB port at
// byte addresses 0 (long press ticks), 4 (blink ticks) and 8 (animation repeats) and should
// only be written while no tick is in flight.
`include "status_led_button_sequencer_top_defines.svh"

module status_led_button_sequencer_top import slbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   slbs_req_if.sink              req_ch,
   slbs_rsp_if.source            rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type      cfg;

   // input register
   logic         in_valid_ff;
   req_item_type in_item_ff;
   req_item_type req_item;

   // response register
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type core_result;

   logic         req_fire;
   logic         advance;
   logic         reboot_shown;

   // configuration registers
   slbs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_item.button_pressed = req_ch.button_pressed;
   assign req_item.command_valid  = req_ch.command_valid;
   assign req_item.command        = req_ch.command;

   // a tick moves on when the response register is empty or draining this cycle
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_fire   = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_item;
      end
   end

   // sequencer state and single-tick update
   slbs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.grn_led        = out_item_ff.grn_led;
   assign rsp_ch.ylw_led        = out_item_ff.ylw_led;
   assign rsp_ch.red_led        = out_item_ff.red_led;
   assign rsp_ch.reboot_request = out_item_ff.reboot_request;

   // response register holds a reboot request
   assign reboot_shown = out_valid_ff && out_item_ff.reboot_request;

   // a reboot request, once delivered, stays in every later response
   `SLBS_ASSERT_NEXT(a_reboot_sticky, clock, reset, reboot_shown, out_item_ff.reboot_request)
   // a held tick is never dropped from the input register
   `SLBS_ASSERT_NEXT(a_in_held, clock, reset, in_valid_ff && !advance, in_valid_ff)
   // a new transfer into a full input register only when the old tick moves on
   `SLBS_ASSERT_NOW(a_no_overwrite, clock, reset, req_fire && in_valid_ff, advance)

endmodule
